@@ design/glpf_pkg.sv @@
// Shared widths, constants and types for the graph layout pair force unit.
// Used by the channel interfaces, the root and divider pipelines and the top level.
`default_nettype none
package glpf_pkg;

    localparam int POS_W    = 16;
    localparam int DIF_W    = POS_W + 1;
    localparam int MAG_W    = 16;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int D2_W     = SQ_W + 1;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ROOT_W   = 25;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 1;
    localparam int KK_W     = 2 * CFG_W;
    localparam int KKG_W    = KK_W + CFG_W;
    localparam int NEAR_W   = 17;
    localparam int RMAG_W   = 9;
    localparam int PROD_W   = 57;
    localparam int APROD_W  = MAG_W + ROOT_W;
    localparam int NUM_W    = 64;
    localparam int DEN_W    = 32;
    localparam int FORCE_W  = 32;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int DIV_STAGES = DEN_W + 1;

    localparam logic [D2_W-1:0]  REPULSE_LIMIT = D2_W'(102400);
    localparam logic [CFG_W-1:0] IDEAL_RESET   = CFG_W'(1600);
    localparam logic [CFG_W-1:0] GAIN_RESET    = CFG_W'(4096);

    localparam logic [CFG_IDX_W-1:0] CFG_IDEAL_DISTANCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPULSION_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTRACTION_GAIN = 2'd2;

    localparam logic FUNC_ATTRACT = 1'b1;

    // Per item control and operands carried alongside the square root pipeline.
    typedef struct packed {
        logic               att;
        logic               skip;
        logic               zero;
        logic               negx;
        logic               negy;
        logic [MAG_W-1:0]   ax;
        logic [MAG_W-1:0]   ay;
        logic [NEAR_W-1:0]  d2;
        logic [KKG_W-1:0]   kkg;
    } t_side;

    // Per item control carried alongside the dividers.
    typedef struct packed {
        logic skip;
        logic zero;
        logic negx;
        logic negy;
    } t_tail;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic                      skipped;
    } t_result;

endpackage
`default_nettype wire

@@ design/glpf_ifs.sv @@
// Valid/ready channel interfaces for node pair items and force result items.
// Depends on glpf_pkg for field widths.
`default_nettype none
interface glpf_in_if import glpf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [POS_W-1:0]  first_x;
    logic signed [POS_W-1:0]  first_y;
    logic signed [POS_W-1:0]  second_x;
    logic signed [POS_W-1:0]  second_y;
    logic                     first_pinned;
    logic                     second_pinned;

    modport source (output valid, func, first_x, first_y, second_x, second_y,
                    first_pinned, second_pinned, input ready);
    modport sink   (input valid, func, first_x, first_y, second_x, second_y,
                    first_pinned, second_pinned, output ready);
endinterface

interface glpf_out_if import glpf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [FORCE_W-1:0]  force_x;
    logic signed [FORCE_W-1:0]  force_y;
    logic                       skipped;

    modport source (output valid, force_x, force_y, skipped, input ready);
    modport sink   (input valid, force_x, force_y, skipped, output ready);
endinterface
`default_nettype wire

@@ design/graph_layout_pair_force.sv @@
// Pair force unit for force-directed graph layout.
// Input channel i_in carries one node pair item: selector func (0 repulsion,
// 1 attraction), both positions in signed Q12.4 and both pinned flags. Output
// channel o_out carries the force on the first node in signed Q24.8, saturated,
// and a skipped flag; the caller applies the negated force to the second node.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data by the user,
// only while idle; the block does not enforce this. Index 0 ideal distance k,
// 1 repulsion gain, 2 attraction gain. Throughput is one item per cycle unless the
// output stalls. An accepted item passes three front stages, 25 stages of the
// square root pipeline, two multiply stages, 33 stages of the divider pipelines, a
// saturation stage and the output register. The divider chain, one quotient bit per
// stage after its range check, sets the depth. When the receiver stalls, the result
// waits in the output register and the next one in a skid register; the whole
// pipeline then holds and i_in.ready drops until the skid register empties. Reset
// clears all valid bits and restores the registers to k = 100 px and unit gains.
`default_nettype none
module graph_layout_pair_force import glpf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    glpf_in_if.sink                    i_in,
    glpf_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    logic [CFG_W-1:0] r_ideal;
    logic [CFG_W-1:0] r_rep_gain;
    logic [CFG_W-1:0] r_att_gain;
    logic [CFG_W-1:0] k_eff;

    logic en;

    // Front stages.
    logic              r1_v, r2_v, r3_v;
    logic [DIF_W-1:0]  r1_dx, r1_dy;
    logic              r1_att, r1_both;
    logic [MAG_W-1:0]  r2_ax, r2_ay;
    logic [SQ_W-1:0]   r2_sqx, r2_sqy;
    logic [KK_W-1:0]   r2_kk;
    logic              r2_att, r2_both, r2_negx, r2_negy;
    logic [D2_W-1:0]   r3_d2;
    logic [KKG_W-1:0]  r3_kkg;
    logic [MAG_W-1:0]  r3_ax, r3_ay;
    logic              r3_att, r3_both, r3_negx, r3_negy;

    logic [DIF_W-1:0]  abs_x, abs_y;
    t_side             side_in;

    t_side             r_sq_side [0:SQ_STAGES-1];
    logic              r_sq_v    [0:SQ_STAGES-1];
    logic [ROOT_W-1:0] root;

    // Multiply stages.
    t_side             sq_out;
    logic [PROD_W-1:0] px, py;
    logic [DEN_W-1:0]  den;
    logic              r_m1_v, r_m2_v;
    logic [PROD_W-1:0] r_m1_px, r_m1_py;
    logic [DEN_W-1:0]  r_m1_den, r_m2_den;
    logic              r_m1_att;
    t_tail             r_m1_tail, r_m2_tail;
    logic [PROD_W-1:0] r_m2_nx, r_m2_ny;

    t_tail             r_dv_tail [0:DIV_STAGES-1];
    logic              r_dv_v    [0:DIV_STAGES-1];
    logic [DEN_W-1:0]  quo_x, quo_y;
    logic              ovf_x, ovf_y;

    t_tail             dv_out;
    t_result           fin;
    logic              r_f_v;
    t_result           r_f;

    t_result           r_out, r_skid;
    logic              r_out_v, r_skid_v;

    function automatic logic [FORCE_W-1:0] sat_force(input logic neg, input logic ovf,
                                                     input logic [DEN_W-1:0] quo);
        logic [FORCE_W-1:0] res;
        if (ovf || quo[DEN_W-1]) begin
            res = neg ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
        end else begin
            res = neg ? FORCE_W'(-quo) : FORCE_W'(quo);
        end
        return res;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ideal    <= IDEAL_RESET;
            r_rep_gain <= GAIN_RESET;
            r_att_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDEAL_DISTANCE:  r_ideal    <= i_cfg_data;
                CFG_REPULSION_GAIN:  r_rep_gain <= i_cfg_data;
                CFG_ATTRACTION_GAIN: r_att_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign k_eff = (r_ideal == '0) ? CFG_W'(1) : r_ideal;

    // The pipeline advances as one; only a full skid register holds it.
    assign en         = !r_skid_v;
    assign i_in.ready = en;

    always_comb begin
        abs_x = r1_dx[DIF_W-1] ? DIF_W'(-r1_dx) : r1_dx;
        abs_y = r1_dy[DIF_W-1] ? DIF_W'(-r1_dy) : r1_dy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx   <= {i_in.second_x[POS_W-1], i_in.second_x}
                     - {i_in.first_x[POS_W-1], i_in.first_x};
            r1_dy   <= {i_in.second_y[POS_W-1], i_in.second_y}
                     - {i_in.first_y[POS_W-1], i_in.first_y};
            r1_att  <= (i_in.func == FUNC_ATTRACT);
            r1_both <= i_in.first_pinned && i_in.second_pinned;

            r2_ax   <= abs_x[MAG_W-1:0];
            r2_ay   <= abs_y[MAG_W-1:0];
            r2_sqx  <= abs_x[MAG_W-1:0] * abs_x[MAG_W-1:0];
            r2_sqy  <= abs_y[MAG_W-1:0] * abs_y[MAG_W-1:0];
            r2_kk   <= k_eff * k_eff;
            r2_att  <= r1_att;
            r2_both <= r1_both;
            // Attraction pulls toward the second node, repulsion pushes away.
            r2_negx <= r1_att ? r1_dx[DIF_W-1] : (!r1_dx[DIF_W-1] && (r1_dx != '0));
            r2_negy <= r1_att ? r1_dy[DIF_W-1] : (!r1_dy[DIF_W-1] && (r1_dy != '0));

            r3_d2   <= D2_W'(r2_sqx) + D2_W'(r2_sqy);
            r3_kkg  <= r2_kk * r_rep_gain;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_att  <= r2_att;
            r3_both <= r2_both;
            r3_negx <= r2_negx;
            r3_negy <= r2_negy;
        end
    end

    always_comb begin
        side_in.att  = r3_att;
        side_in.skip = r3_both || (!r3_att && (r3_d2 > REPULSE_LIMIT));
        side_in.zero = (r3_d2 == '0);
        side_in.negx = r3_negx;
        side_in.negy = r3_negy;
        side_in.ax   = r3_ax;
        side_in.ay   = r3_ay;
        side_in.d2   = r3_d2[NEAR_W-1:0];
        side_in.kkg  = r3_kkg;
    end

    // Distance in Q.12 is the root of the squared distance scaled by 2^16.
    glpf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  ({1'b0, r3_d2, 16'b0}),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_side[0] <= side_in;
            for (int i = 1; i < SQ_STAGES; i++) begin
                r_sq_side[i] <= r_sq_side[i-1];
            end
        end
    end

    assign sq_out = r_sq_side[SQ_STAGES-1];

    always_comb begin
        if (sq_out.att) begin
            px  = PROD_W'(sq_out.ax * root);
            py  = PROD_W'(sq_out.ay * root);
            den = {k_eff, 16'b0};
        end else begin
            px  = PROD_W'(sq_out.ax[RMAG_W-1:0] * sq_out.kkg);
            py  = PROD_W'(sq_out.ay[RMAG_W-1:0] * sq_out.kkg);
            den = DEN_W'({sq_out.d2, 8'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_px        <= px;
            r_m1_py        <= py;
            r_m1_den       <= den;
            r_m1_att       <= sq_out.att;
            r_m1_tail.skip <= sq_out.skip;
            r_m1_tail.zero <= sq_out.zero;
            r_m1_tail.negx <= sq_out.negx;
            r_m1_tail.negy <= sq_out.negy;

            r_m2_nx   <= r_m1_att ? PROD_W'(r_m1_px[APROD_W-1:0] * r_att_gain) : r_m1_px;
            r_m2_ny   <= r_m1_att ? PROD_W'(r_m1_py[APROD_W-1:0] * r_att_gain) : r_m1_py;
            r_m2_den  <= r_m1_den;
            r_m2_tail <= r_m1_tail;
        end
    end

    glpf_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NUM_W'(r_m2_nx)),
        .i_den (r_m2_den),
        .o_quo (quo_x),
        .o_ovf (ovf_x)
    );

    glpf_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NUM_W'(r_m2_ny)),
        .i_den (r_m2_den),
        .o_quo (quo_y),
        .o_ovf (ovf_y)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_tail[0] <= r_m2_tail;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_dv_tail[i] <= r_dv_tail[i-1];
            end
        end
    end

    assign dv_out = r_dv_tail[DIV_STAGES-1];

    always_comb begin
        fin.skipped = dv_out.skip;
        if (dv_out.skip || dv_out.zero) begin
            fin.force_x = '0;
            fin.force_y = '0;
        end else begin
            fin.force_x = sat_force(dv_out.negx, ovf_x, quo_x);
            fin.force_y = sat_force(dv_out.negy, ovf_y, quo_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f <= fin;
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_f_v  <= 1'b0;
            for (int i = 0; i < SQ_STAGES; i++) begin
                r_sq_v[i] <= 1'b0;
            end
            for (int i = 0; i < DIV_STAGES; i++) begin
                r_dv_v[i] <= 1'b0;
            end
        end else if (en) begin
            r1_v      <= i_in.valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r_sq_v[0] <= r3_v;
            for (int i = 1; i < SQ_STAGES; i++) begin
                r_sq_v[i] <= r_sq_v[i-1];
            end
            r_m1_v    <= r_sq_v[SQ_STAGES-1];
            r_m2_v    <= r_m1_v;
            r_dv_v[0] <= r_m2_v;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_dv_v[i] <= r_dv_v[i-1];
            end
            r_f_v     <= r_dv_v[DIV_STAGES-1];
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (r_f_v) begin
            if (r_out_v && !o_out.ready) begin
                r_skid   <= r_f;
                r_skid_v <= 1'b1;
            end else begin
                r_out    <= r_f;
                r_out_v  <= 1'b1;
            end
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out.valid   = r_out_v;
    assign o_out.force_x = r_out.force_x;
    assign o_out.force_y = r_out.force_y;
    assign o_out.skipped = r_out.skipped;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds an item while the output register is empty");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.skipped) |-> (r_out.force_x == '0 && r_out.force_y == '0))
        else $error("skipped item carries a nonzero force");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && o_out.ready) |=> (r_out_v && !r_skid_v))
        else $error("skid register did not move into the output register");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_f_v))
        else $error("pipeline advanced while the skid register was full");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_v && !r_skid_v && !r_f_v))
        else $error("valid state survived reset");

endmodule
`default_nettype wire

@@ design/glpf_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on glpf_pkg for the radicand and root widths.
`default_nettype none
module glpf_sqrt import glpf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0]      o_root
);

    logic [RAD_W-1:0]  r_rad  [0:ROOT_W-2];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-2];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (g == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        always_comb begin
            rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial  = {1'b0, root_in, 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[g] <= {root_in[ROOT_W-2:0], ge};
            end
        end

        if (g < ROOT_W - 1) begin : g_carry
            logic [REM_W+1:0] diff;
            assign diff = rem_sh - trial;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[g] <= rad_in << 2;
                    r_rem[g] <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule
`default_nettype wire

@@ design/glpf_div.sv @@
// Pipelined restoring divider with a quotient range check in front.
// Depends on glpf_pkg for widths; one quotient bit per register stage after the first.
`default_nettype none
module glpf_div import glpf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic [DEN_W-1:0]       o_quo,
    output logic                   o_ovf
);

    logic [DEN_W-1:0] r_rem [0:DEN_W-1];
    logic [DEN_W-1:0] r_den [0:DEN_W-1];
    logic [DEN_W-1:0] r_low [0:DEN_W];
    logic             r_ovf [0:DEN_W];

    logic [DEN_W-1:0] hi;
    logic             ovf;

    // A quotient of 2^32 or more only matters as saturation, so it is flagged up front.
    assign hi  = i_num[NUM_W-1:DEN_W];
    assign ovf = (hi >= i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= ovf ? '0 : hi;
            r_low[0] <= i_num[DEN_W-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= ovf;
        end
    end

    for (genvar g = 1; g <= DEN_W; g++) begin : g_stage
        logic [DEN_W:0] rr;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb begin
            rr   = {r_rem[g-1], r_low[g-1][DEN_W-1]};
            diff = rr - {1'b0, r_den[g-1]};
            ge   = (rr >= {1'b0, r_den[g-1]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_low[g] <= {r_low[g-1][DEN_W-2:0], ge};
                r_ovf[g] <= r_ovf[g-1];
            end
        end

        if (g < DEN_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= ge ? diff[DEN_W-1:0] : rr[DEN_W-1:0];
                    r_den[g] <= r_den[g-1];
                end
            end
        end
    end

    assign o_quo = r_low[DEN_W];
    assign o_ovf = r_ovf[DEN_W];

endmodule
`default_nettype wire
